// File: hdl/dtas_pkg.sv
// shared constants and calendar tables for the date/time adder
package dtas_pkg;

	localparam int NUM_STAGES = 7;

	typedef logic [NUM_STAGES:1] stage_en_t;

	localparam logic [11:0] FIRST_YEAR = 12'd1900;
	localparam logic [11:0] LAST_YEAR  = 12'd2015;

	// reciprocal multipliers, exact over the operand ranges used
	localparam logic [26:0] RECIP_675  = 27'd101806633;  // shift 36, x < 2^26
	localparam int          SHIFT_675  = 36;
	localparam logic [18:0] RECIP_365  = 19'd367720;     // shift 27, x < 2^18
	localparam int          SHIFT_365  = 27;
	localparam logic [17:0] RECIP_3600 = 18'd149131;     // shift 29, x < 2^17
	localparam int          SHIFT_3600 = 29;
	localparam logic [12:0] RECIP_60   = 13'd4370;       // shift 18, x < 2^12
	localparam int          SHIFT_60   = 18;

	// 1 jan 1900 counted from 1 mar 1600, and days in a 400-year era
	localparam logic [17:0] EPOCH_DOE = 18'd109513;
	localparam logic [17:0] ERA_DAYS  = 18'd146097;

	function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
		logic [4:0] n;
		case (mo)
			4'd2: n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	// days before the first of a month in a common year
	function automatic logic [8:0] cum_days(input logic [3:0] mo);
		logic [8:0] n;
		case (mo)
			4'd2: n = 9'd31;
			4'd3: n = 9'd59;
			4'd4: n = 9'd90;
			4'd5: n = 9'd120;
			4'd6: n = 9'd151;
			4'd7: n = 9'd181;
			4'd8: n = 9'd212;
			4'd9: n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			4'd12: n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// first day of each month in a year that starts in march
	function automatic logic [8:0] mar_start(input logic [3:0] mp);
		logic [8:0] n;
		case (mp)
			4'd1: n = 9'd31;
			4'd2: n = 9'd61;
			4'd3: n = 9'd92;
			4'd4: n = 9'd122;
			4'd5: n = 9'd153;
			4'd6: n = 9'd184;
			4'd7: n = 9'd214;
			4'd8: n = 9'd245;
			4'd9: n = 9'd275;
			4'd10: n = 9'd306;
			4'd11: n = 9'd337;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// File: hdl/dtas_front.sv
// stage 1: range check, field clamping, start day number and total seconds
module dtas_front (
	input  logic                clk,
	input  dtas_pkg::stage_en_t en,
	input  logic [4:0]          start_day,
	input  logic [3:0]          start_month,
	input  logic [11:0]         start_year,
	input  logic [4:0]          start_hour,
	input  logic [5:0]          start_minute,
	input  logic [5:0]          start_second,
	input  logic [31:0]         seconds_to_add,
	output logic                ok_s1,
	output logic [16:0]         d0_s1,
	output logic [32:0]         total_s1
);
	import dtas_pkg::*;

	logic        yr_ok;
	logic [11:0] yoff;
	logic [6:0]  t;
	logic        leap;
	logic [3:0]  mo;
	logic [4:0]  ml;
	logic [4:0]  dy;
	logic [6:0]  leaps;
	logic [16:0] d0;
	logic [32:0] total;

	always_comb begin
		yr_ok = (start_year >= FIRST_YEAR) && (start_year <= LAST_YEAR);
		yoff  = start_year - FIRST_YEAR;
		t     = yoff[6:0];
		leap  = (t[1:0] == 2'd0) && (t != 7'd0);
		if (start_month == 4'd0) begin
			mo = 4'd1;
		end else if (start_month > 4'd12) begin
			mo = 4'd12;
		end else begin
			mo = start_month;
		end
		ml = month_len(mo, leap);
		dy = (start_day == 5'd0) ? 5'd1 : start_day;
		if (dy > ml) begin
			dy = ml;
		end
		// leap days in 1900..year-1, 1900 itself is common
		leaps = (t == 7'd0) ? 7'd0 : ((t - 7'd1) >> 2);
		d0 = 17'({10'd0, t} * 17'd365) + 17'(leaps) + 17'(cum_days(mo))
			+ 17'(leap && (mo > 4'd2)) + 17'(dy) - 17'd1;
		total = 33'({28'd0, start_hour} * 33'd3600) + 33'({27'd0, start_minute} * 33'd60)
			+ 33'(start_second) + 33'(seconds_to_add);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ok_s1    <= yr_ok;
			d0_s1    <= d0;
			total_s1 <= total;
		end
	end

endmodule

// File: hdl/dtas_divday.sv
// stages 2-3: split total seconds into whole days and time of day, era split
module dtas_divday (
	input  logic                clk,
	input  dtas_pkg::stage_en_t en,
	input  logic                ok_s1,
	input  logic [16:0]         d0_s1,
	input  logic [32:0]         total_s1,
	output logic                ok_s3,
	output logic [16:0]         tod_s3,
	output logic                era_s3,
	output logic [17:0]         doe_s3
);
	import dtas_pkg::*;

	logic [25:0] x;
	logic [52:0] prod;
	logic        ok_s2;
	logic [16:0] d0_s2;
	logic [16:0] q_s2;
	logic [25:0] x_s2;
	logic [6:0]  lo_s2;
	logic [26:0] rem;
	logic [17:0] g;
	logic        era;

	// 86400 = 675 * 128: shift out the power of two, then reciprocal multiply
	always_comb begin
		x    = total_s1[32:7];
		prod = 53'(x) * 53'(RECIP_675);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ok_s2 <= ok_s1;
			d0_s2 <= d0_s1;
			q_s2  <= prod[SHIFT_675 +: 17];
			x_s2  <= x;
			lo_s2 <= total_s1[6:0];
		end
	end

	always_comb begin
		rem = {1'b0, x_s2} - 27'(q_s2 * 27'd675);
		g   = 18'(d0_s2) + 18'(q_s2) + EPOCH_DOE;
		era = (g >= ERA_DAYS);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ok_s3  <= ok_s2;
			tod_s3 <= {rem[9:0], lo_s2};
			era_s3 <= era;
			doe_s3 <= era ? (g - ERA_DAYS) : g;
		end
	end

endmodule

// File: hdl/dtas_civil.sv
// stages 4-7: day of era to year, month and day
module dtas_civil (
	input  logic                clk,
	input  dtas_pkg::stage_en_t en,
	input  logic                ok_s3,
	input  logic                era_s3,
	input  logic [17:0]         doe_s3,
	output logic [4:0]          end_day,
	output logic [3:0]          end_month,
	output logic [11:0]         end_year,
	output logic                valid_res
);
	import dtas_pkg::*;

	logic [15:0] qd;
	logic [34:0] p4;
	logic [2:0]  c36524;
	logic [17:0] yoe_num;
	logic        ok_s4, era_s4, ok_s5, era_s5, ok_s6, era_s6;
	logic [17:0] doe_s4, doe_s5;
	logic [17:0] num_s4;
	logic [36:0] p5;
	logic [8:0]  yoe_s5, yoe_s6;
	logic [1:0]  c100;
	logic [17:0] ybase;
	logic [17:0] doy_full;
	logic [8:0]  doy_s6;
	logic [3:0]  mp;
	logic [3:0]  mo;
	logic [8:0]  dd;
	logic [11:0] yr;

	always_comb begin
		qd = doe_s3[17:2];
		p4 = 35'(qd) * 35'(RECIP_365);
		c36524 = 3'(doe_s3 >= 18'd36524) + 3'(doe_s3 >= 18'd73048)
			+ 3'(doe_s3 >= 18'd109572) + 3'(doe_s3 >= 18'd146096);
		// year of era numerator: drop leap days
		yoe_num = doe_s3 - 18'(p4[SHIFT_365 +: 8]) + 18'(c36524)
			- 18'(doe_s3 == 18'd146096);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ok_s4  <= ok_s3;
			era_s4 <= era_s3;
			doe_s4 <= doe_s3;
			num_s4 <= yoe_num;
		end
	end

	always_comb begin
		p5 = 37'(num_s4) * 37'(RECIP_365);
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ok_s5  <= ok_s4;
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			yoe_s5 <= p5[SHIFT_365 +: 9];
		end
	end

	always_comb begin
		c100 = 2'(yoe_s5 >= 9'd100) + 2'(yoe_s5 >= 9'd200) + 2'(yoe_s5 >= 9'd300);
		ybase = 18'(yoe_s5 * 18'd365) + 18'(yoe_s5 >> 2) - 18'(c100);
		doy_full = doe_s5 - ybase;
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			ok_s6  <= ok_s5;
			era_s6 <= era_s5;
			yoe_s6 <= yoe_s5;
			doy_s6 <= doy_full[8:0];
		end
	end

	always_comb begin
		mp = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s6 >= mar_start(4'(k))) begin
				mp = 4'(k);
			end
		end
		dd = doy_s6 - mar_start(mp) + 9'd1;
		mo = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
		yr = 12'd1600 + 12'(yoe_s6) + (era_s6 ? 12'd400 : 12'd0)
			+ 12'(mo <= 4'd2);
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			valid_res <= ok_s6;
			end_day   <= ok_s6 ? dd[4:0] : 5'd0;
			end_month <= ok_s6 ? mo : 4'd0;
			end_year  <= ok_s6 ? yr : 12'd0;
		end
	end

endmodule

// File: hdl/dtas_clock.sv
// stages 4-7: time of day to hour, minute and second
module dtas_clock (
	input  logic                clk,
	input  dtas_pkg::stage_en_t en,
	input  logic                ok_s3,
	input  logic [16:0]         tod_s3,
	output logic [4:0]          end_hour,
	output logic [5:0]          end_minute,
	output logic [5:0]          end_second
);
	import dtas_pkg::*;

	logic [34:0] ph;
	logic        ok_s4, ok_s5, ok_s6;
	logic [16:0] tod_s4;
	logic [4:0]  hour_s4, hour_s5, hour_s6;
	logic [16:0] rem;
	logic [11:0] rem_s5, rem_s6;
	logic [24:0] pm;
	logic [5:0]  min_s6;
	logic [11:0] sec;

	always_comb begin
		ph = 35'(tod_s3) * 35'(RECIP_3600);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ok_s4   <= ok_s3;
			tod_s4  <= tod_s3;
			hour_s4 <= ph[SHIFT_3600 +: 5];
		end
	end

	always_comb begin
		rem = tod_s4 - 17'(hour_s4 * 17'd3600);
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ok_s5   <= ok_s4;
			hour_s5 <= hour_s4;
			rem_s5  <= rem[11:0];
		end
	end

	always_comb begin
		pm = 25'(rem_s5) * 25'(RECIP_60);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			ok_s6   <= ok_s5;
			hour_s6 <= hour_s5;
			rem_s6  <= rem_s5;
			min_s6  <= pm[SHIFT_60 +: 6];
		end
	end

	always_comb begin
		sec = rem_s6 - 12'(min_s6 * 12'd60);
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			end_hour   <= ok_s6 ? hour_s6 : 5'd0;
			end_minute <= ok_s6 ? min_s6 : 6'd0;
			end_second <= ok_s6 ? sec[5:0] : 6'd0;
		end
	end

endmodule

// File: hdl/date_time_add_seconds.sv
// top level of the gregorian date/time plus seconds adder
//
// input channel: in_valid/in_stall carry one word holding a start date, a start
// time and a 32-bit count of seconds; a word is taken on a clock edge with
// in_valid high and in_stall low
// output channel: out_valid/out_stall carry one result word per input word,
// in order; valid_res is low (and all date/time fields zero) when the start
// year lies outside 1900..2015
// throughput: one word per cycle while the output is not stalled; seven pipeline stages, each with a valid bit
// stall: a stalled output holds its word; earlier stages keep advancing into
// empty slots, so in_stall rises only once every stage holds a word
// reset: arst_n clears all stage valid bits at once; data registers are not reset
// arithmetic: division by 86400, 3600, 60 and 365 uses reciprocal multipliers;
// the date is rebuilt from a day count in 400-year eras starting on 1 march
module date_time_add_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  start_day,
	input  logic [3:0]  start_month,
	input  logic [11:0] start_year,
	input  logic [4:0]  start_hour,
	input  logic [5:0]  start_minute,
	input  logic [5:0]  start_second,
	input  logic [31:0] seconds_to_add,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  end_day,
	output logic [3:0]  end_month,
	output logic [11:0] end_year,
	output logic [4:0]  end_hour,
	output logic [5:0]  end_minute,
	output logic [5:0]  end_second,
	output logic        valid_res
);
	import dtas_pkg::*;

	logic [NUM_STAGES:1] vld_q;
	stage_en_t           en;

	logic        ok_s1;
	logic [16:0] d0_s1;
	logic [32:0] total_s1;
	logic        ok_s3;
	logic [16:0] tod_s3;
	logic        era_s3;
	logic [17:0] doe_s3;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en[NUM_STAGES] = !vld_q[NUM_STAGES] || !out_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	dtas_front u_front (
		.clk            (clk),
		.en             (en),
		.start_day      (start_day),
		.start_month    (start_month),
		.start_year     (start_year),
		.start_hour     (start_hour),
		.start_minute   (start_minute),
		.start_second   (start_second),
		.seconds_to_add (seconds_to_add),
		.ok_s1          (ok_s1),
		.d0_s1          (d0_s1),
		.total_s1       (total_s1)
	);

	dtas_divday u_divday (
		.clk      (clk),
		.en       (en),
		.ok_s1    (ok_s1),
		.d0_s1    (d0_s1),
		.total_s1 (total_s1),
		.ok_s3    (ok_s3),
		.tod_s3   (tod_s3),
		.era_s3   (era_s3),
		.doe_s3   (doe_s3)
	);

	dtas_civil u_civil (
		.clk       (clk),
		.en        (en),
		.ok_s3     (ok_s3),
		.era_s3    (era_s3),
		.doe_s3    (doe_s3),
		.end_day   (end_day),
		.end_month (end_month),
		.end_year  (end_year),
		.valid_res (valid_res)
	);

	dtas_clock u_clock (
		.clk        (clk),
		.en         (en),
		.ok_s3      (ok_s3),
		.tod_s3     (tod_s3),
		.end_hour   (end_hour),
		.end_minute (end_minute),
		.end_second (end_second)
	);

`ifndef ASSERT_OFF
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> end_month >= 4'd1 && end_month <= 4'd12 && end_day != 5'd0)
		else $error("month or day out of range on a valid result");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> end_year == 12'd0 && end_day == 5'd0 && end_hour == 5'd0)
		else $error("rejected word carries nonzero fields");
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> end_hour < 5'd24 && end_minute < 6'd60 && end_second < 6'd60)
		else $error("time of day out of range");
	a_full_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && vld_q == '1)
		else $error("input stalled while the pipeline has room");
`endif

endmodule
